// ----- sv/periodic_task_tick_scheduler_core_defines.svh -----
// Assertion macros shared by the scheduler modules
`ifndef PERIODIC_TASK_TICK_SCHEDULER_CORE_DEFINES_SVH
`define PERIODIC_TASK_TICK_SCHEDULER_CORE_DEFINES_SVH

// Check a consequence in the same cycle as its trigger
`define PTTS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Check a consequence in the cycle after its trigger
`define PTTS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- sv/ptts_pkg.sv -----
// Types, constants and helpers of the periodic task tick scheduler
package ptts_pkg;

  localparam int NUM_SLOTS   = 8;
  localparam int MAX_RESULTS = 8;
  localparam int SLOT_W      = $clog2(NUM_SLOTS);
  localparam int CNT_W       = $clog2(MAX_RESULTS + 1);
  localparam int OP_W        = 3;
  localparam int IDX_W       = 8;
  localparam int PER_W       = 16;
  localparam int KIND_W      = 2;
  localparam int FSLOT_W     = 3;
  localparam int ERR_W       = 2;

  typedef enum logic [OP_W-1:0] {
    OP_TICK, OP_CREATE, OP_SUSPEND, OP_RESUME, OP_DELETE
  } opcode_t;

  typedef enum logic [1:0] {
    ST_EMPTY, ST_RUNNING, ST_SUSPENDED
  } status_t;

  typedef enum logic [KIND_W-1:0] {
    KIND_STATUS, KIND_FIRED, KIND_IDLE_TICK
  } kind_t;

  typedef enum logic [ERR_W-1:0] {
    ERR_OK, ERR_RANGE, ERR_OCCUPIED, ERR_NOTASK
  } err_t;

  typedef enum logic [1:0] {
    S_IDLE, S_CMD, S_WALK, S_FINISH
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic load;
    logic walk_start;
    logic walk_step;
    logic cmd_exec;
    logic finish_push;
  } ctrl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic in_is_tick;
    logic in_is_cmd;
    logic step_push;
    logic slot_last;
    logic out_free;
  } dp_sts_t;

  // Low three bits of a slot number, zero extended for narrow tables
  function automatic logic [FSLOT_W-1:0] fired_bits(input logic [SLOT_W-1:0] s);
    logic [IDX_W-1:0] w;
    w = IDX_W'(s);
    return w[FSLOT_W-1:0];
  endfunction

endpackage

// ----- sv/ptts_if.sv -----
// Command and result channel interfaces of the scheduler
interface ptts_in_if import ptts_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [OP_W-1:0]  opcode;
  logic [IDX_W-1:0] slot_index;
  logic [PER_W-1:0] period_ticks;

  modport source (output valid, output opcode, output slot_index, output period_ticks,
                  input ready);
  modport sink   (input valid, input opcode, input slot_index, input period_ticks,
                  output ready);
endinterface

interface ptts_out_if import ptts_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [KIND_W-1:0]  kind;
  logic [FSLOT_W-1:0] fired_slot;
  logic [ERR_W-1:0]   error_code;
  logic               last;

  modport source (output valid, output kind, output fired_slot, output error_code,
                  output last, input ready);
  modport sink   (input valid, input kind, input fired_slot, input error_code,
                  input last, output ready);
endinterface

// ----- sv/periodic_task_tick_scheduler_core.sv -----
// Top level of the periodic task tick scheduler
//
//   channel   dir   handshake          payload
//   in_ch     in    valid / ready      opcode, slot_index, period_ticks
//   out_ch    out   valid / ready      kind, fired_slot, error_code, last
//
// A command is accepted, then executed into the result register once it is free.
// A tick is accepted, then walks the slots in order through the
// period/countdown memory (read one slot ahead, write back the current one),
// then gives the final result. Unknown opcodes are accepted and give no result.
// Reset clears every slot to empty; period and countdown are rewritten on create.
// A full result register stalls the walk only when a fire has to go out.
module periodic_task_tick_scheduler_core import ptts_pkg::*; (
  input logic         clk,
  input logic         rst_n,
  ptts_in_if.sink     in_ch,
  ptts_out_if.source  out_ch
);

  ctrl_cmd_t cmd;
  dp_sts_t   sts;

  ptts_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  ptts_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .in_opcode       (in_ch.opcode),
    .in_slot_index   (in_ch.slot_index),
    .in_period_ticks (in_ch.period_ticks),
    .out_valid       (out_ch.valid),
    .out_ready       (out_ch.ready),
    .out_kind        (out_ch.kind),
    .out_fired_slot  (out_ch.fired_slot),
    .out_error_code  (out_ch.error_code),
    .out_last        (out_ch.last)
  );

endmodule

// ----- sv/ptts_ctrl.sv -----
// Controller state machine of the scheduler
`include "periodic_task_tick_scheduler_core_defines.svh"

module ptts_ctrl import ptts_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  dp_sts_t    sts,
  output ctrl_cmd_t  cmd
);

  state_t state_r, state_nxt;

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load = 1'b1;
          if (sts.in_is_tick) begin
            cmd.walk_start = 1'b1;
            state_nxt      = S_WALK;
          end else if (sts.in_is_cmd) begin
            state_nxt = S_CMD;
          end
        end
      end
      S_CMD: begin
        if (sts.out_free) begin
          cmd.cmd_exec = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      S_WALK: begin
        // stall only when a pending fire must go out and the output is full
        if (!sts.step_push || sts.out_free) begin
          cmd.walk_step = 1'b1;
          if (sts.slot_last) begin
            state_nxt = S_FINISH;
          end
        end
      end
      S_FINISH: begin
        if (sts.out_free) begin
          cmd.finish_push = 1'b1;
          state_nxt       = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  `PTTS_ASSERT_NEXT(a_walk_stall_holds, (state_r == S_WALK) && sts.step_push && !sts.out_free, state_r == S_WALK, "walk advanced while output blocked")
  `PTTS_ASSERT_NEXT(a_unknown_op_dropped, (state_r == S_IDLE) && in_valid && !sts.in_is_tick && !sts.in_is_cmd, state_r == S_IDLE, "unknown opcode left idle")
  `PTTS_ASSERT_NEXT(a_finish_to_idle, (state_r == S_FINISH) && sts.out_free, state_r == S_IDLE, "tick did not complete after final result")

endmodule

// ----- sv/ptts_dp.sv -----
// Datapath of the scheduler: slot table, walk pipeline and result register
`include "periodic_task_tick_scheduler_core_defines.svh"

module ptts_dp import ptts_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  ctrl_cmd_t          cmd,
  output dp_sts_t            sts,
  input  logic [OP_W-1:0]    in_opcode,
  input  logic [IDX_W-1:0]   in_slot_index,
  input  logic [PER_W-1:0]   in_period_ticks,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [KIND_W-1:0]  out_kind,
  output logic [FSLOT_W-1:0] out_fired_slot,
  output logic [ERR_W-1:0]   out_error_code,
  output logic               out_last
);

  // Latched command
  logic [OP_W-1:0]  op_r;
  logic [IDX_W-1:0] idx_r;
  logic [PER_W-1:0] per_r;

  // Slot table: status in flops, period and countdown in a memory
  status_t            status_r [NUM_SLOTS];
  logic [2*PER_W-1:0] mem [NUM_SLOTS];
  logic [2*PER_W-1:0] rd_r;

  // Walk state
  logic [SLOT_W-1:0] walk_idx_r;
  logic [CNT_W-1:0]  cnt_r;
  logic              pend_v_r;
  logic [SLOT_W-1:0] pend_slot_r;

  // Result register
  logic               out_valid_r;
  logic [KIND_W-1:0]  kind_r;
  logic [FSLOT_W-1:0] fslot_r;
  logic [ERR_W-1:0]   err_r;
  logic               last_r;

  logic               out_free;
  logic               rd_en;
  logic [SLOT_W-1:0]  rd_addr;
  logic               wr_en;
  logic [SLOT_W-1:0]  wr_addr;
  logic [2*PER_W-1:0] wr_data;
  logic               push;
  logic [KIND_W-1:0]  push_kind;
  logic [FSLOT_W-1:0] push_fslot;
  logic [ERR_W-1:0]   push_err;
  logic               push_last;

  status_t           cur_st;
  logic [PER_W-1:0]  cur_cd;
  logic [PER_W-1:0]  cur_per;
  logic              run, zero, due;
  logic              slot_last;

  logic              in_range;
  logic [SLOT_W-1:0] cmd_slot;
  status_t           sel_st;
  status_t           new_st;
  logic [ERR_W-1:0]  cmd_err;
  logic              cmd_mem_wr;
  logic              st_we;

  assign out_free  = !out_valid_r || out_ready;
  assign slot_last = (walk_idx_r == SLOT_W'(NUM_SLOTS - 1));

  // Classify the offered command
  assign sts.in_is_tick = (in_opcode == OP_TICK);
  assign sts.in_is_cmd  = (in_opcode != OP_TICK) && (in_opcode <= OP_DELETE);
  assign sts.slot_last  = slot_last;
  assign sts.out_free   = out_free;

  // Current walk slot
  assign cur_st  = status_r[walk_idx_r];
  assign cur_cd  = rd_r[PER_W-1:0];
  assign cur_per = rd_r[2*PER_W-1:PER_W];
  assign run     = (cur_st == ST_RUNNING);
  assign zero    = (cur_cd == '0);
  assign due     = run && zero && (cnt_r < CNT_W'(MAX_RESULTS));
  assign sts.step_push = due && pend_v_r;

  // Command decode against the addressed slot
  assign in_range = (idx_r < IDX_W'(NUM_SLOTS));
  assign cmd_slot = idx_r[SLOT_W-1:0];
  assign sel_st   = in_range ? status_r[cmd_slot] : ST_EMPTY;

  always_comb begin
    cmd_err    = ERR_OK;
    new_st     = sel_st;
    cmd_mem_wr = 1'b0;
    if (!in_range) begin
      cmd_err = ERR_RANGE;
    end else begin
      case (op_r)
        OP_CREATE: begin
          if (sel_st != ST_EMPTY) begin
            cmd_err = ERR_OCCUPIED;
          end else begin
            new_st     = ST_RUNNING;
            cmd_mem_wr = 1'b1;
          end
        end
        OP_SUSPEND: begin
          if (sel_st == ST_RUNNING) new_st = ST_SUSPENDED;
          else cmd_err = ERR_NOTASK;
        end
        OP_RESUME: begin
          if (sel_st == ST_SUSPENDED) new_st = ST_RUNNING;
          else cmd_err = ERR_NOTASK;
        end
        OP_DELETE: begin
          if (sel_st != ST_EMPTY) new_st = ST_EMPTY;
          else cmd_err = ERR_NOTASK;
        end
        default: begin
          cmd_err = ERR_OK;
        end
      endcase
    end
  end

  assign st_we = cmd.cmd_exec && in_range && (cmd_err == ERR_OK);

  // Memory read port: slot 0 at tick start, then one ahead of the walk
  assign rd_en   = cmd.walk_start || (cmd.walk_step && !slot_last);
  assign rd_addr = cmd.walk_start ? '0 : SLOT_W'(walk_idx_r + 1'b1);

  // Memory write port: create, or reload / decrement during the walk
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = walk_idx_r;
    wr_data = {cur_per, cur_per};
    if (cmd.cmd_exec) begin
      wr_en   = cmd_mem_wr;
      wr_addr = cmd_slot;
      wr_data = {per_r, per_r};
    end else if (cmd.walk_step && run) begin
      if (!zero) begin
        wr_en   = 1'b1;
        wr_data = {cur_per, cur_cd - 1'b1};
      end else if (due) begin
        wr_en   = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_r <= mem[rd_addr];
    end
  end

  // Select a result to transfer into the output register
  always_comb begin
    push       = 1'b0;
    push_kind  = KIND_STATUS;
    push_fslot = '0;
    push_err   = ERR_OK;
    push_last  = 1'b1;
    if (cmd.walk_step && sts.step_push) begin
      push       = 1'b1;
      push_kind  = KIND_FIRED;
      push_fslot = fired_bits(pend_slot_r);
      push_last  = 1'b0;
    end else if (cmd.finish_push) begin
      push = 1'b1;
      if (pend_v_r) begin
        push_kind  = KIND_FIRED;
        push_fslot = fired_bits(pend_slot_r);
      end else begin
        push_kind = KIND_IDLE_TICK;
      end
    end else if (cmd.cmd_exec) begin
      push     = 1'b1;
      push_err = cmd_err;
    end
  end

  // Control registers: status table, walk counters, output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_SLOTS; i++) begin
        status_r[i] <= ST_EMPTY;
      end
      walk_idx_r  <= '0;
      cnt_r       <= '0;
      pend_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (st_we) begin
        status_r[cmd_slot] <= new_st;
      end
      if (cmd.walk_start) begin
        walk_idx_r <= '0;
        cnt_r      <= '0;
        pend_v_r   <= 1'b0;
      end else if (cmd.walk_step) begin
        if (!slot_last) begin
          walk_idx_r <= SLOT_W'(walk_idx_r + 1'b1);
        end
        if (due) begin
          cnt_r    <= CNT_W'(cnt_r + 1'b1);
          pend_v_r <= 1'b1;
        end
      end
      if (push) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r  <= in_opcode;
      idx_r <= in_slot_index;
      per_r <= in_period_ticks;
    end
    if (cmd.walk_step && due) begin
      pend_slot_r <= walk_idx_r;
    end
    if (push) begin
      kind_r  <= push_kind;
      fslot_r <= push_fslot;
      err_r   <= push_err;
      last_r  <= push_last;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_kind       = kind_r;
  assign out_fired_slot = fslot_r;
  assign out_error_code = err_r;
  assign out_last       = last_r;

  `PTTS_ASSERT_NOW(a_fire_limit, 1'b1, cnt_r <= CNT_W'(MAX_RESULTS), "fire count above limit")
  `PTTS_ASSERT_NOW(a_push_into_free, push, !out_valid_r || out_ready, "result overwrote a waiting result")
  `PTTS_ASSERT_NEXT(a_walk_init, cmd.walk_start, (cnt_r == '0) && !pend_v_r && (walk_idx_r == '0), "walk state not cleared at tick start")

endmodule
